@@ rtl/wsr_pkg.sv @@
package wsr_pkg;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CfgThresholdLeft  = 2'd0,
    CfgThresholdRight = 2'd1,
    CfgDeadZone       = 2'd2
  } cfg_index_e;

  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 12;
  localparam int unsigned ThrW      = 12;
  localparam int unsigned DeadW     = 8;
  localparam int unsigned EdgesW    = 8;
  localparam int unsigned DriveW    = 13;

  localparam logic [ThrW-1:0]  ThresholdReset = 12'd3351;
  localparam logic [DeadW-1:0] DeadZoneReset  = 8'd5;

  // Width of the count above the dead zone handed to the drive function.
  localparam int unsigned ExcessW = 12;

  // floor(x/15) = (x * 2185) >> 15, exact for x below 4681.
  localparam logic [11:0] Div15Mul   = 12'd2185;
  localparam int unsigned Div15Shift = 15;

  // Result of one rate channel for one tick.
  typedef struct packed {
    logic [EdgesW-1:0] edges;
    logic              active;
    logic [DriveW-1:0] drive;
  } rate_res_t;

  // floor(x*256/15) = 17*x + floor(x/15), since 256 = 15*17 + 1.
  function automatic logic [DriveW-1:0] drive_of(input logic [ExcessW-1:0] x);
    logic [ExcessW+11:0] prod;
    logic [ExcessW-1:0]  quot;
    logic [ExcessW+5:0]  sum;
    prod = {12'd0, x} * {{ExcessW{1'b0}}, Div15Mul};
    quot = ExcessW'(prod >> Div15Shift);
    sum  = {2'd0, x, 4'd0} + {6'd0, x} + {6'd0, quot};
    return sum[DriveW-1:0];
  endfunction

endpackage

@@ rtl/wsr_ram.sv @@
module wsr_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 250
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/wsr_rate.sv @@
module wsr_rate
  import wsr_pkg::*;
#(
  parameter int unsigned CNT_W = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             advance_i,
  input  logic             edge_i,
  input  logic             old_mark_i,
  input  logic [DeadW-1:0] dead_i,
  output rate_res_t        res_o
);

  logic [CNT_W-1:0]   count_q, count_d;
  logic [ExcessW-1:0] count_x, dead_x, excess;
  logic               active;

  // The mark leaving the window is removed and the new one added.
  assign count_d = count_q - CNT_W'(old_mark_i) + CNT_W'(edge_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (advance_i) begin
      count_q <= count_d;
    end
  end

  assign count_x = ExcessW'(count_d);
  assign dead_x  = ExcessW'(dead_i);
  assign active  = count_x >= dead_x;
  assign excess  = count_x - dead_x;

  always_comb begin
    res_o.edges  = count_x[EdgesW-1:0];
    res_o.active = active;
    res_o.drive  = active ? drive_of(excess) : '0;
  end

endmodule

@@ rtl/windowed_spike_rate_drive_unit.sv @@
// Windowed spike-rate drive unit. Every input transfer is one sample tick with a left and a
// right converter sample; every tick gives exactly one result transfer, in order, through
// stage one and the output register. One tick is accepted in every cycle while the output
// side does not stall; the rate is set by the edge ring, a single RAM of WINDOW entries
// holding the left and right marks side by side, which takes one read and one write per
// tick. Each channel reports its thresholded level, the number of rising edges of that level
// within the last WINDOW ticks (the current one included), whether that count has reached
// the dead zone, and an unsigned Q5.8 drive of floor((count - dead_zone) * 256 / 15), zero
// below the dead zone and not saturated. After reset the window is empty at once; there is
// no clearing pass, as marks from the first lap through the ring are read as zero.
// Configuration writes are always ready and must be made while no tick is in flight.
module windowed_spike_rate_drive_unit
  import wsr_pkg::*;
#(
  parameter int unsigned WINDOW      = 250,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,

  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [SAMPLE_BITS-1:0] sample_left_i,
  input  logic [SAMPLE_BITS-1:0] sample_right_i,

  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   level_left_o,
  output logic                   level_right_o,
  output logic [EdgesW-1:0]      edges_left_o,
  output logic [EdgesW-1:0]      edges_right_o,
  output logic                   active_left_o,
  output logic                   active_right_o,
  output logic [DriveW-1:0]      drive_left_o,
  output logic [DriveW-1:0]      drive_right_o,

  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIndexW-1:0]   cfg_index_i,
  input  logic [CfgDataW-1:0]    cfg_data_i
);

  localparam int unsigned PosW = $clog2(WINDOW);
  localparam int unsigned CntW = $clog2(WINDOW + 1);
  localparam logic [PosW-1:0] PosLast = PosW'(WINDOW - 1);

  // Configuration registers. The port never pushes back.
  logic [ThrW-1:0]  thr_left_q, thr_right_q;
  logic [DeadW-1:0] dead_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_left_q  <= ThresholdReset;
      thr_right_q <= ThresholdReset;
      dead_q      <= DeadZoneReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_e'(cfg_index_i))
        CfgThresholdLeft:  thr_left_q  <= cfg_data_i[ThrW-1:0];
        CfgThresholdRight: thr_right_q <= cfg_data_i[ThrW-1:0];
        CfgDeadZone:       dead_q      <= cfg_data_i[DeadW-1:0];
        default: ;
      endcase
    end
  end

  // Flow control. Stage one holds a tick whose ring read is in flight; the output register
  // holds a finished result. A tick may enter while stage one drains into a free output slot.
  logic out_valid_q, s1_valid_q;
  logic out_free, s1_adv, accept;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  // Thresholds are compared in the sample width: zero-extended or cut to SAMPLE_BITS.
  logic [15:0]            thr_left_w, thr_right_w;
  logic [SAMPLE_BITS-1:0] thr_left_s, thr_right_s;
  logic                   level_left, level_right;
  logic                   last_left_q, last_right_q;

  assign thr_left_w  = {{(16 - ThrW){1'b0}}, thr_left_q};
  assign thr_right_w = {{(16 - ThrW){1'b0}}, thr_right_q};
  assign thr_left_s  = thr_left_w[SAMPLE_BITS-1:0];
  assign thr_right_s = thr_right_w[SAMPLE_BITS-1:0];
  assign level_left  = sample_left_i >= thr_left_s;
  assign level_right = sample_right_i >= thr_right_s;

  // Ring position and first-lap tracking. Until the position has wrapped once, the entry
  // being read was never written, so its mark is taken as zero.
  logic [PosW-1:0] pos_q;
  logic            wrapped_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      wrapped_q    <= 1'b0;
      last_left_q  <= 1'b0;
      last_right_q <= 1'b0;
    end else if (accept) begin
      last_left_q  <= level_left;
      last_right_q <= level_right;
      if (pos_q == PosLast) begin
        pos_q     <= '0;
        wrapped_q <= 1'b1;
      end else begin
        pos_q <= pos_q + PosW'(1);
      end
    end
  end

  // Stage one registers: the tick's levels and edge marks, where it sits in the ring, and
  // whether the old mark read there is real.
  logic            s1_level_left_q, s1_level_right_q;
  logic            s1_edge_left_q, s1_edge_right_q;
  logic            s1_old_ok_q;
  logic [PosW-1:0] s1_pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_level_left_q  <= level_left;
      s1_level_right_q <= level_right;
      s1_edge_left_q   <= level_left && !last_left_q;
      s1_edge_right_q  <= level_right && !last_right_q;
      s1_old_ok_q      <= wrapped_q;
      s1_pos_q         <= pos_q;
    end
  end

  // Edge ring: bit 0 is the left mark, bit 1 the right. The read is issued when a tick is
  // accepted and its data stays put while stage one is held. The new marks are written back
  // when the tick leaves stage one; the next tick always reads a different entry.
  logic [1:0] old_marks;

  wsr_ram #(
    .WIDTH(2),
    .DEPTH(WINDOW)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (s1_adv),
    .waddr_i(s1_pos_q),
    .wdata_i({s1_edge_right_q, s1_edge_left_q}),
    .re_i   (accept),
    .raddr_i(pos_q),
    .rdata_o(old_marks)
  );

  // Running counts and drive values, one unit per channel.
  rate_res_t res_left, res_right;

  wsr_rate #(
    .CNT_W(CntW)
  ) u_rate_left (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (s1_adv),
    .edge_i    (s1_edge_left_q),
    .old_mark_i(old_marks[0] && s1_old_ok_q),
    .dead_i    (dead_q),
    .res_o     (res_left)
  );

  wsr_rate #(
    .CNT_W(CntW)
  ) u_rate_right (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (s1_adv),
    .edge_i    (s1_edge_right_q),
    .old_mark_i(old_marks[1] && s1_old_ok_q),
    .dead_i    (dead_q),
    .res_o     (res_right)
  );

  // Output register.
  rate_res_t out_left_q, out_right_q;
  logic      out_level_left_q, out_level_right_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_left_q        <= res_left;
      out_right_q       <= res_right;
      out_level_left_q  <= s1_level_left_q;
      out_level_right_q <= s1_level_right_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign level_left_o   = out_level_left_q;
  assign level_right_o  = out_level_right_q;
  assign edges_left_o   = out_left_q.edges;
  assign edges_right_o  = out_right_q.edges;
  assign active_left_o  = out_left_q.active;
  assign active_right_o = out_right_q.active;
  assign drive_left_o   = out_left_q.drive;
  assign drive_right_o  = out_right_q.drive;

endmodule

@@ rtl/wsr_checker.sv @@
module wsr_checker
  import wsr_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic              level_left_o,
  input logic              level_right_o,
  input logic [EdgesW-1:0] edges_left_o,
  input logic [EdgesW-1:0] edges_right_o,
  input logic [DriveW-1:0] drive_left_o
);

  logic out_xfer;
  assign out_xfer = out_valid_o && !out_stall_i;

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result valid dropped while stalled");

  a_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(edges_left_o) && $stable(drive_left_o))
    else $error("stalled result changed");

  // Over one tick the window loses at most one mark and gains at most one.
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer ##1 out_xfer |->
      (edges_left_o == $past(edges_left_o)) ||
      (edges_left_o == $past(edges_left_o) + 8'd1) ||
      ($past(edges_left_o) == edges_left_o + 8'd1))
    else $error("left edge count moved by more than one between ticks");

  // A new edge can only be counted on a tick whose level is high.
  a_rise_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer ##1 (out_xfer && edges_left_o == $past(edges_left_o) + 8'd1) |-> level_left_o)
    else $error("left count rose on a low tick");

  a_rise_right: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer ##1 (out_xfer && edges_right_o == $past(edges_right_o) + 8'd1) |-> level_right_o)
    else $error("right count rose on a low tick");

endmodule

bind windowed_spike_rate_drive_unit wsr_checker u_wsr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .level_left_o (level_left_o),
  .level_right_o(level_right_o),
  .edges_left_o (edges_left_o),
  .edges_right_o(edges_right_o),
  .drive_left_o (drive_left_o)
);
